// File: design/stream_id_renumber_table_macros.svh
// assertion helpers for the stream id renumbering block
// every macro samples on clk_i and is quiet while rst_ni is low
`ifndef STREAM_ID_RENUMBER_TABLE_MACROS_SVH
`define STREAM_ID_RENUMBER_TABLE_MACROS_SVH

// implication or plain property, checked on every clock edge out of reset
`define SRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define SRT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: design/srt_pkg.sv
`default_nettype none

package srt_pkg;

  localparam int unsigned StreamIdW = 32;
  localparam int unsigned MappedIdW = 12;
  localparam int unsigned CounterW  = 11;
  localparam int unsigned SourceW   = 3;

  localparam logic [CounterW-1:0] CounterMax = 11'd2047;

  typedef struct packed {
    logic [SourceW-1:0]          source_index;
    logic signed [StreamIdW-1:0] stream_id;
  } in_req_t;

  typedef struct packed {
    logic signed [MappedIdW-1:0] mapped_id;
    logic                        newly_assigned;
    logic                        table_full;
  } out_rsp_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [StreamIdW-1:0] seen_id;
    logic [MappedIdW-1:0] assigned_id;
  } entry_t;

  // request to the id generator
  typedef struct packed {
    logic take;
    logic negative;
  } id_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StDecide,
    StResp
  } state_e;

endpackage

`default_nettype wire

// File: design/srt_mem.sv
`default_nettype none

module srt_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire srt_pkg::entry_t   wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output      srt_pkg::entry_t   rdata_o
);

  srt_pkg::entry_t mem_q [Depth];
  srt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/srt_idgen.sv
`default_nettype none

module srt_idgen (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire srt_pkg::id_req_t                  id_req_i,
  output      logic [srt_pkg::MappedIdW-1:0]     id_code_o
);

  logic [srt_pkg::CounterW-1:0] pos_q, pos_d;
  logic [srt_pkg::CounterW-1:0] neg_q, neg_d;
  logic [srt_pkg::CounterW-1:0] pos_nx, neg_nx;

  // both counters stick at their top value
  assign pos_nx = (pos_q == srt_pkg::CounterMax) ? pos_q : pos_q + 11'd1;
  assign neg_nx = (neg_q == srt_pkg::CounterMax) ? neg_q : neg_q + 11'd1;

  always_comb begin
    pos_d = pos_q;
    neg_d = neg_q;
    if (id_req_i.take) begin
      if (id_req_i.negative) begin
        neg_d = neg_nx;
      end else begin
        pos_d = pos_nx;
      end
    end
  end

  // negative ids are the two's complement of the magnitude
  assign id_code_o = id_req_i.negative ? (12'd0 - {1'b0, neg_nx}) : {1'b0, pos_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      neg_q <= '0;
    end else begin
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
  end

endmodule

`default_nettype wire

// File: design/srt_ctrl.sv
`default_nettype none
`include "stream_id_renumber_table_macros.svh"

module srt_ctrl #(
  parameter int unsigned NUM_SOURCES = 8,
  parameter int unsigned MAX_STREAMS = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire srt_pkg::in_req_t              in_req_i,
  output      srt_pkg::id_req_t              id_req_o,
  input  wire logic [srt_pkg::MappedIdW-1:0] id_code_i,
  output      logic                          res_valid_o,
  input  wire logic                          res_ready_i,
  output      srt_pkg::out_rsp_t             res_o
);

  localparam int unsigned Depth = NUM_SOURCES * MAX_STREAMS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned CW    = $clog2(MAX_STREAMS + 1);

  srt_pkg::state_e   state_q, state_d;
  logic [SW-1:0]     src_idx_q, src_idx_d;
  logic [31:0]       sid_q, sid_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     idx_nx;
  srt_pkg::out_rsp_t res_q, res_d;
  logic [CW-1:0]     cnt_q [NUM_SOURCES];
  logic              cnt_we;

  logic              src_ok;
  logic [SW-1:0]     in_src_idx;
  logic [AW-1:0]     base_addr;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  srt_pkg::entry_t   mem_wdata, mem_rdata;

  srt_mem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign src_ok     = 32'(in_req_i.source_index) < 32'(NUM_SOURCES);
  assign in_src_idx = SW'(in_req_i.source_index);
  assign base_addr  = AW'(src_idx_q) * AW'(MAX_STREAMS);
  assign idx_nx     = idx_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    src_idx_d   = src_idx_q;
    sid_d       = sid_q;
    n_d         = n_q;
    idx_d       = idx_q;
    res_d       = res_q;
    cnt_we      = 1'b0;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    id_req_o    = '0;
    mem_re      = 1'b0;
    mem_raddr   = base_addr + AW'(idx_q);
    mem_we      = 1'b0;
    mem_waddr   = base_addr + AW'(n_q);
    mem_wdata   = '{seen_id: sid_q, assigned_id: id_code_i};

    unique case (state_q)
      srt_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          src_idx_d = in_src_idx;
          sid_d     = in_req_i.stream_id;
          idx_d     = '0;
          if (!src_ok) begin
            n_d     = '0;
            res_d   = '0;
            state_d = srt_pkg::StResp;
          end else begin
            n_d = cnt_q[in_src_idx];
            if (cnt_q[in_src_idx] == '0) begin
              state_d = srt_pkg::StDecide;
            end else begin
              state_d = srt_pkg::StStart;
            end
          end
        end
      end
      srt_pkg::StStart: begin
        mem_re  = 1'b1;
        state_d = srt_pkg::StScan;
      end
      srt_pkg::StScan: begin
        if (mem_rdata.seen_id == sid_q) begin
          res_d   = '{mapped_id: signed'(mem_rdata.assigned_id),
                      newly_assigned: 1'b0, table_full: 1'b0};
          state_d = srt_pkg::StResp;
        end else if (idx_nx == n_q) begin
          state_d = srt_pkg::StDecide;
        end else begin
          idx_d     = idx_nx;
          mem_re    = 1'b1;
          mem_raddr = base_addr + AW'(idx_nx);
        end
      end
      srt_pkg::StDecide: begin
        if (n_q == CW'(MAX_STREAMS)) begin
          res_d = '{mapped_id: '0, newly_assigned: 1'b0, table_full: 1'b1};
        end else begin
          mem_we            = 1'b1;
          cnt_we            = 1'b1;
          id_req_o.take     = 1'b1;
          id_req_o.negative = sid_q[31];
          res_d = '{mapped_id: signed'(id_code_i), newly_assigned: 1'b1,
                    table_full: 1'b0};
        end
        state_d = srt_pkg::StResp;
      end
      srt_pkg::StResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = srt_pkg::StIdle;
        end
      end
      default: begin
        state_d = srt_pkg::StIdle;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        cnt_q[s] <= '0;
      end
    end else if (cnt_we) begin
      cnt_q[src_idx_q] <= n_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    src_idx_q <= src_idx_d;
    sid_q     <= sid_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
  end

  // scan pointer stays inside the filled part of the table
  `SRT_ASSERT(a_scan_in_range, (state_q == srt_pkg::StScan) |-> (idx_q < n_q), "scan past fill")
  // a new mapping is never also reported as a full table
  `SRT_ASSERT_NEVER(a_new_not_full, (state_q == srt_pkg::StResp) && res_q.newly_assigned && res_q.table_full, "new and full")
  // an append grows that source's fill by exactly one
  `SRT_ASSERT(a_append_grows, mem_we |=> (cnt_q[$past(src_idx_q)] == ($past(n_q) + CW'(1))), "fill not bumped")

endmodule

`default_nettype wire

// File: design/stream_id_renumber_table.sv
// channel | direction | payload              | handshake
// in      | to block  | srt_pkg::in_req_t    | in_valid_i / in_stall_o
// out     | from block| srt_pkg::out_rsp_t   | out_valid_o / out_stall_i
//
// a hit at entry k (counting from 0) reads entries 0 to k in the scan state, then answers
// a miss reads every entry of that source, then appends in the decide state; an empty table skips the scan
// bounded by one memory read per table entry
// source index out of range goes straight to the response state and answers all zero
// reset clears the fill counts and both id counters, the table memory is not cleared
// out_stall_i holds a finished result in the output register while the next request is taken
`default_nettype none

module stream_id_renumber_table #(
  parameter int unsigned NUM_SOURCES = 8,
  parameter int unsigned MAX_STREAMS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire srt_pkg::in_req_t  in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      srt_pkg::out_rsp_t out_rsp_o
);

  srt_pkg::id_req_t                 id_req;
  logic [srt_pkg::MappedIdW-1:0]    id_code;
  logic                             res_valid;
  logic                             res_ready;
  srt_pkg::out_rsp_t                res;

  logic                             out_valid_q, out_valid_d;
  srt_pkg::out_rsp_t                out_rsp_q;

  // scan sequencer with the per-source table memory and fill counts
  srt_ctrl #(
    .NUM_SOURCES (NUM_SOURCES),
    .MAX_STREAMS (MAX_STREAMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .id_req_o    (id_req),
    .id_code_i   (id_code),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // shared saturating counters for new positive and negative ids
  srt_idgen u_idgen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .id_req_i  (id_req),
    .id_code_o (id_code)
  );

  // output register frees when empty or when the current result is taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // block configuration under test
  localparam int unsigned NumSources = 8;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned SrcW       = srt_pkg::SourceW;

  // longest quiet stretch: a full scan plus the longest stall and gap, many times over
  localparam int unsigned IdleLimit  = 2000;
  // cycles left after the last result to catch stray output
  localparam int unsigned TailCycles = 200;
  // cap on printed mismatch lines, counting goes on
  localparam int unsigned MaxPrinted = 50;

  // source that gets filled to the brim
  localparam logic [srt_pkg::SourceW-1:0] FullSource = 3'd5;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  srt_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  srt_pkg::out_rsp_t out_rsp;

  always #1 clk = ~clk;

  stream_id_renumber_table #(
    .NUM_SOURCES(NumSources),
    .MAX_STREAMS(TableDepth)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the per-source tables and the shared id counters
  // ---------------------------------------------------------------------------
  logic [srt_pkg::StreamIdW-1:0] known_id  [NumSources][TableDepth];
  logic [srt_pkg::MappedIdW-1:0] known_map [NumSources][TableDepth];
  int unsigned                   fill_count [NumSources] = '{default: 0};
  logic [srt_pkg::CounterW-1:0]  pos_issued = '0;
  logic [srt_pkg::CounterW-1:0]  neg_issued = '0;

  // predicted results, oldest first
  srt_pkg::out_rsp_t mapping_q [$];

  int unsigned n_sent      = 0;
  int unsigned n_hits      = 0;
  int unsigned n_new       = 0;
  int unsigned n_full      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_errors    = 0;
  int unsigned idle_cycles = 0;

  // set during stretches with no idling on either side
  bit quiet = 1'b0;

  // lookup in insertion order, append on a miss, reject when the table is full
  function automatic srt_pkg::out_rsp_t renumber(srt_pkg::in_req_t req);
    srt_pkg::out_rsp_t             rsp;
    int unsigned                   src;
    int unsigned                   n;
    logic [srt_pkg::MappedIdW-1:0] code;
    rsp = '0;
    src = 32'(req.source_index);
    if (src >= NumSources) return rsp;
    n = fill_count[src];
    for (int unsigned i = 0; i < n; i++) begin
      if (known_id[src][i] == req.stream_id) begin
        rsp.mapped_id = known_map[src][i];
        n_hits++;
        return rsp;
      end
    end
    if (n >= TableDepth) begin
      // nothing stored, counters untouched
      rsp.table_full = 1'b1;
      n_full++;
      return rsp;
    end
    if (req.stream_id[srt_pkg::StreamIdW-1]) begin
      // negative ids count down from -1 and stick at the bottom
      if (neg_issued < srt_pkg::CounterMax) neg_issued++;
      code = -{1'b0, neg_issued};
    end else begin
      // zero and positive ids count up from +1 and stick at the top
      if (pos_issued < srt_pkg::CounterMax) pos_issued++;
      code = {1'b0, pos_issued};
    end
    known_id[src][n]  = req.stream_id;
    known_map[src][n] = code;
    fill_count[src]   = n + 1;
    rsp.mapped_id      = code;
    rsp.newly_assigned = 1'b1;
    n_new++;
    return rsp;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall: random bursts of stall and go
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !quiet && ($urandom_range(99) < 40);
      stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // result checker and progress counter, values sampled as they were before the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    srt_pkg::out_rsp_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (mapping_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %p", out_rsp));
        end else begin
          want = mapping_q.pop_front();
          if (out_rsp.mapped_id !== want.mapped_id)
            report_mismatch($sformatf("result %0d mapped_id %0d, predicted %0d",
                                      n_checked, out_rsp.mapped_id, want.mapped_id));
          if (out_rsp.newly_assigned !== want.newly_assigned)
            report_mismatch($sformatf("result %0d newly_assigned %b, predicted %b",
                                      n_checked, out_rsp.newly_assigned, want.newly_assigned));
          if (out_rsp.table_full !== want.table_full)
            report_mismatch($sformatf("result %0d table_full %b, predicted %b",
                                      n_checked, out_rsp.table_full, want.table_full));
          n_checked++;
        end
      end
    end
  end

  // no progress for too long ends the run
  initial begin : watchdog
    wait (rst_n);
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("stream_id_renumber_table verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request; valid stays up into the next call when no gap follows
  task automatic send_request(input logic [srt_pkg::SourceW-1:0] src,
                              input logic [srt_pkg::StreamIdW-1:0] sid);
    int unsigned      gap;
    srt_pkg::in_req_t req;
    gap              = pick_gap();
    req.source_index = src;
    req.stream_id    = sid;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // taken at this edge
    mapping_q.push_back(renumber(req));
    n_sent++;
  endtask

  // sender holds off until every predicted result has been seen
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mapping_q.size() != 0) @(posedge clk);
  endtask

  // repeats of known ids, a shared pool of ids common to all sources, and fresh ids
  task automatic send_random_request();
    logic [srt_pkg::SourceW-1:0]   src;
    logic [srt_pkg::StreamIdW-1:0] sid;
    int unsigned                   r;
    src = SrcW'($urandom_range(NumSources - 1));
    r   = $urandom_range(99);
    if (r < 45 && fill_count[src] != 0) begin
      sid = known_id[src][$urandom_range(fill_count[src] - 1)];
    end else if (r < 60) begin
      case ($urandom_range(4))
        0:       sid = 32'h0000_0000;
        1:       sid = 32'hFFFF_FFFF;
        2:       sid = 32'h7FFF_FFFF;
        3:       sid = 32'h8000_0000;
        default: sid = 32'($urandom_range(7)) - 32'd4;
      endcase
    end else begin
      sid = $urandom();
    end
    send_request(src, sid);
  endtask

  // extremes of the id, both signs, hits and the same id in separate sources
  task automatic test_directed();
    send_request(3'd0, 32'h0000_0000);  // zero takes the positive counter
    send_request(3'd0, 32'hFFFF_FFFF);  // first negative id
    send_request(3'd0, 32'h7FFF_FFFF);
    send_request(3'd0, 32'h8000_0000);
    send_request(3'd0, 32'h0000_0000);  // hit on the first entry
    send_request(3'd0, 32'h8000_0000);  // hit on a negative mapping
    send_request(3'd7, 32'h0000_0000);  // same id in another source gets its own mapping
    send_request(3'd7, 32'h7FFF_FFFF);
    send_request(3'd3, 32'h5555_5555);
    send_request(3'd3, 32'hAAAA_AAAA);
    send_request(3'd0, 32'h0000_0001);  // one bit off an existing entry is a miss
    send_request(3'd0, 32'hFFFF_FFFF);
    send_request(3'd7, 32'h0000_0000);
    send_request(3'd3, 32'hAAAA_AAAA);
    for (int unsigned s = 1; s < NumSources - 1; s++) send_request(SrcW'(s), $urandom());
    pause_until_drained();
  endtask

  // fresh random ids into the source being filled, with the odd repeat mixed in
  task automatic send_random_full_fill();
    if (fill_count[FullSource] != 0 && $urandom_range(9) == 0)
      send_request(FullSource, known_id[FullSource][$urandom_range(fill_count[FullSource] - 1)]);
    else
      send_request(FullSource, $urandom());
  endtask

  // fill one source to capacity, then misses are rejected and hits still work
  task automatic test_table_full();
    while (fill_count[FullSource] < TableDepth) send_random_full_fill();
    repeat (4) send_request(FullSource, $urandom());
    send_request(FullSource, 32'h8000_0000);
    send_request(FullSource, known_id[FullSource][0]);
    send_request(FullSource, known_id[FullSource][TableDepth - 1]);
    send_request(FullSource, known_id[FullSource][$urandom_range(TableDepth - 1)]);
    pause_until_drained();
  endtask

  // a stretch with no gaps and no stall
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (100) send_random_request();
    quiet = 1'b0;
    pause_until_drained();
  endtask

  // long random run that fills more sources, with periodic drain pauses
  task automatic test_random_mix();
    for (int unsigned i = 0; i < 1150; i++) begin
      send_random_request();
      if (i % 300 == 299) pause_until_drained();
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_back_to_back();
    test_random_mix();

    pause_until_drained();
    // anything appearing now has no request behind it
    repeat (TailCycles) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d new mappings, %0d hits, %0d rejected as full",
             n_sent, n_checked, n_new, n_hits, n_full);
    $display("ids handed out: %0d positive, %0d negative; %0d mismatches",
             pos_issued, neg_issued, n_errors);
    if (n_errors == 0 && mapping_q.size() == 0) begin
      $display("stream_id_renumber_table verification clean");
    end else begin
      $display("stream_id_renumber_table verification failed");
    end
    $finish;
  end

endmodule
